// File: rtl/pet_pkg.sv
// Shared types, constants and register codes for the pointer event translator.
package pet_pkg;

   localparam int COORD_BITS  = 16;
   localparam int POS_BITS    = 16;
   localparam int VALUE_BITS  = 17;
   localparam int SIZE_BITS   = 13;
   localparam int MASK_BITS   = 8;
   localparam int NUM_BUTTONS = 3;
   localparam int INDEX_BITS  = 2;
   localparam int WDATA_BITS  = 13;

   typedef enum logic [1:0] {
      MODE_NONE     = 2'd0,
      MODE_ABSOLUTE = 2'd1,
      MODE_RELATIVE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      EVENT_REL_MOTION = 2'd0,
      EVENT_ABS_MOTION = 2'd1,
      EVENT_BUTTON     = 2'd2
   } event_kind_type;

   localparam logic [INDEX_BITS-1:0] REG_POINTER_MODE  = 2'd0;
   localparam logic [INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd1;
   localparam logic [INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd2;

   localparam logic [1:0] BUTTON_LEFT   = 2'd0;
   localparam logic [1:0] BUTTON_MIDDLE = 2'd1;
   localparam logic [1:0] BUTTON_RIGHT  = 2'd2;

   localparam logic [1:0]           RESET_MODE   = 2'd1;
   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd1920;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd1080;

   typedef struct packed {
      logic [1:0]           mode;
      logic [SIZE_BITS-1:0] width;
      logic [SIZE_BITS-1:0] height;
   } cfg_type;

   typedef struct packed {
      event_kind_type                kind;
      logic signed [VALUE_BITS-1:0]  value_x;
      logic signed [VALUE_BITS-1:0]  value_y;
      logic [NUM_BUTTONS-1:0]        change;
      logic [NUM_BUTTONS-1:0]        level;
   } item_type;

endpackage

// File: rtl/pet_csr.sv
// Configuration registers: pointer mode and screen dimensions.
module pet_csr
   import pet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [INDEX_BITS-1:0] csr_index,
   input  logic [WDATA_BITS-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [1:0]           mode_ff;
   logic [SIZE_BITS-1:0] width_ff;
   logic [SIZE_BITS-1:0] height_ff;
   logic [1:0]           mode_in;
   logic [SIZE_BITS-1:0] width_in;
   logic [SIZE_BITS-1:0] height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_POINTER_MODE:  mode_in   = csr_wdata[1:0];
            REG_SCREEN_WIDTH:  width_in  = csr_wdata[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: height_in = csr_wdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RESET_MODE;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.mode   = mode_ff;
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

endmodule

// File: rtl/pet_input_reg.sv
// Input register that holds one pointer report until the translator takes it.
module pet_input_reg
   import pet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MASK_BITS-1:0]  req_button_mask,
   input  logic [POS_BITS-1:0]   req_pos_x,
   input  logic [POS_BITS-1:0]   req_pos_y,
   input  logic                  pop,
   output logic                  held_valid,
   output logic [MASK_BITS-1:0]  held_mask,
   output logic [COORD_BITS-1:0] held_x,
   output logic [COORD_BITS-1:0] held_y
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [MASK_BITS-1:0]  mask_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic                  take;

   assign req_ready = !valid_ff || pop;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mask_ff <= req_button_mask;
         x_ff    <= req_pos_x[COORD_BITS-1:0];
         y_ff    <= req_pos_y[COORD_BITS-1:0];
      end
   end

   assign held_valid = valid_ff;
   assign held_mask  = mask_ff;
   assign held_x     = x_ff;
   assign held_y     = y_ff;

endmodule

// File: rtl/pet_translate.sv
// Motion and button-change computation with the previous pointer state.
module pet_translate
   import pet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  held_valid,
   input  logic [MASK_BITS-1:0]  held_mask,
   input  logic [COORD_BITS-1:0] held_x,
   input  logic [COORD_BITS-1:0] held_y,
   input  logic                  emit_ready,
   output logic                  pop,
   output logic                  load,
   output item_type              item
);

   logic [COORD_BITS-1:0] prev_x_ff;
   logic [COORD_BITS-1:0] prev_y_ff;
   logic [MASK_BITS-1:0]  prev_buttons_ff;
   logic                  active;
   logic                  relative;

   function automatic logic [VALUE_BITS-1:0] rel_delta(
      input logic [COORD_BITS-1:0] c,
      input logic [SIZE_BITS-1:0]  s,
      input logic [COORD_BITS-1:0] prev
   );
      logic [VALUE_BITS-1:0] ce;
      logic [VALUE_BITS-1:0] se;
      logic [VALUE_BITS-1:0] d;
      ce = VALUE_BITS'(c);
      se = VALUE_BITS'(s);
      priority if (c == '0) begin
         d = VALUE_BITS'(1) - se;
      end else if (s == '0 || ce >= se - VALUE_BITS'(1)) begin
         d = se - VALUE_BITS'(1);
      end else begin
         d = ce - VALUE_BITS'(prev);
      end
      return d;
   endfunction

   always_comb begin
      unique case (cfg.mode)
         MODE_ABSOLUTE: begin
            active   = 1'b1;
            relative = 1'b0;
         end
         MODE_RELATIVE: begin
            active   = 1'b1;
            relative = 1'b1;
         end
         default: begin
            active   = 1'b0;
            relative = 1'b0;
         end
      endcase
   end

   assign pop  = held_valid && (!active || emit_ready);
   assign load = held_valid && active && emit_ready;

   always_comb begin
      if (relative) begin
         item.kind    = EVENT_REL_MOTION;
         item.value_x = $signed(rel_delta(held_x, cfg.width, prev_x_ff));
         item.value_y = $signed(rel_delta(held_y, cfg.height, prev_y_ff));
      end else begin
         item.kind    = EVENT_ABS_MOTION;
         item.value_x = $signed(VALUE_BITS'(held_x));
         item.value_y = $signed(VALUE_BITS'(held_y));
      end
      item.change = held_mask[NUM_BUTTONS-1:0] ^ prev_buttons_ff[NUM_BUTTONS-1:0];
      item.level  = held_mask[NUM_BUTTONS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         prev_buttons_ff <= '0;
      end else if (load) begin
         prev_buttons_ff <= held_mask;
         if (relative) begin
            prev_x_ff <= held_x;
            prev_y_ff <= held_y;
         end
      end
   end

endmodule

// File: rtl/pet_emitter.sv
// Result register that sends the motion event and then each button event.
module pet_emitter
   import pet_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  item_type                     item,
   output logic                         emit_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_event_kind,
   output logic signed [VALUE_BITS-1:0] rsp_value_x,
   output logic signed [VALUE_BITS-1:0] rsp_value_y,
   output logic [1:0]                   rsp_button_index,
   output logic                         rsp_pressed,
   output logic                         rsp_last
);

   logic                         motion_ff;
   logic                         motion_in;
   logic [NUM_BUTTONS-1:0]       pend_ff;
   logic [NUM_BUTTONS-1:0]       pend_in;
   event_kind_type               kind_ff;
   logic signed [VALUE_BITS-1:0] vx_ff;
   logic signed [VALUE_BITS-1:0] vy_ff;
   logic [NUM_BUTTONS-1:0]       level_ff;
   logic [1:0]                   btn_idx;
   logic [NUM_BUTTONS-1:0]       btn_onehot;
   logic [NUM_BUTTONS-1:0]       pend_after;
   logic                         fire;

   always_comb begin
      priority if (pend_ff[0]) begin
         btn_idx    = BUTTON_LEFT;
         btn_onehot = 3'b001;
      end else if (pend_ff[1]) begin
         btn_idx    = BUTTON_MIDDLE;
         btn_onehot = 3'b010;
      end else begin
         btn_idx    = BUTTON_RIGHT;
         btn_onehot = 3'b100;
      end
   end

   assign pend_after = motion_ff ? pend_ff : (pend_ff & ~btn_onehot);
   assign rsp_valid  = motion_ff || (pend_ff != '0);
   assign rsp_last   = (pend_after == '0);
   assign fire       = rsp_valid && rsp_ready;
   assign emit_ready = !rsp_valid || (rsp_ready && rsp_last);

   always_comb begin
      if (motion_ff) begin
         rsp_event_kind   = kind_ff;
         rsp_value_x      = vx_ff;
         rsp_value_y      = vy_ff;
         rsp_button_index = BUTTON_LEFT;
         rsp_pressed      = 1'b0;
      end else begin
         rsp_event_kind   = EVENT_BUTTON;
         rsp_value_x      = '0;
         rsp_value_y      = '0;
         rsp_button_index = btn_idx;
         rsp_pressed      = level_ff[btn_idx];
      end
   end

   always_comb begin
      motion_in = motion_ff;
      pend_in   = pend_ff;
      if (fire) begin
         motion_in = 1'b0;
         pend_in   = pend_after;
      end
      if (load) begin
         motion_in = 1'b1;
         pend_in   = item.change;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff <= 1'b0;
         pend_ff   <= '0;
      end else begin
         motion_ff <= motion_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= item.kind;
         vx_ff    <= item.value_x;
         vy_ff    <= item.value_y;
         level_ff <= item.level;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid || (rsp_ready && rsp_last)))
      else $error("new report loaded over pending results");

   a_motion_leads: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_last) |=> (!rsp_valid || motion_ff))
      else $error("results of a report did not start with motion");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(pend_ff) && $stable(motion_ff)))
      else $error("pending results changed while stalled");

   a_buttons_after_motion: assert property (@(posedge clock) disable iff (reset)
      (fire && motion_ff && !rsp_last) |=> (!motion_ff && pend_ff != '0))
      else $error("button events lost after motion event");

endmodule

// File: rtl/pointer_event_translator_core.sv
// Pointer event translator: remote pointer reports in, motion and button events out.
//
// The req channel takes one report per transaction: button mask and x, y position.
// Each report yields a motion event (absolute position or relative delta, per the
// pointer mode register) followed by one button event for each of left, middle and
// right whose level changed; rsp_last marks the final event of a report. In mode
// none or reserved mode, a report yields no events and leaves the stored state unchanged.
// The csr channel writes the mode and screen size registers; it is always ready.
// Writes are to be made by the user only while no report is in flight; the block
// itself does not enforce this. The first event of a report is offered once the
// report has passed the input register and been loaded into the result register,
// which waits until the events of the previous report have drained. The single
// result register sends one event per cycle while rsp_ready is high; a report in
// mode none or reserved mode leaves the input register without being loaded. The input
// register takes the next report while the current events drain, so reports follow without gaps.
// Reset clears the stored coordinates and buttons, empties both registers and loads
// the default configuration. When the receiver stalls, the current event holds on
// rsp and one further report waits in the input register before req_ready drops.
module pointer_event_translator_core
   import pet_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [MASK_BITS-1:0]         req_button_mask,
   input  logic [POS_BITS-1:0]          req_pos_x,
   input  logic [POS_BITS-1:0]          req_pos_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_event_kind,
   output logic signed [VALUE_BITS-1:0] rsp_value_x,
   output logic signed [VALUE_BITS-1:0] rsp_value_y,
   output logic [1:0]                   rsp_button_index,
   output logic                         rsp_pressed,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [INDEX_BITS-1:0]        csr_index,
   input  logic [WDATA_BITS-1:0]        csr_wdata
);

   cfg_type               cfg;
   logic                  pop;
   logic                  load;
   logic                  emit_ready;
   logic                  held_valid;
   logic [MASK_BITS-1:0]  held_mask;
   logic [COORD_BITS-1:0] held_x;
   logic [COORD_BITS-1:0] held_y;
   item_type              item;

   pet_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pet_input_reg u_input (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_button_mask (req_button_mask),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .pop             (pop),
      .held_valid      (held_valid),
      .held_mask       (held_mask),
      .held_x          (held_x),
      .held_y          (held_y)
   );

   pet_translate u_translate (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .held_valid (held_valid),
      .held_mask  (held_mask),
      .held_x     (held_x),
      .held_y     (held_y),
      .emit_ready (emit_ready),
      .pop        (pop),
      .load       (load),
      .item       (item)
   );

   pet_emitter u_emitter (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .item             (item),
      .emit_ready       (emit_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_value_x      (rsp_value_x),
      .rsp_value_y      (rsp_value_y),
      .rsp_button_index (rsp_button_index),
      .rsp_pressed      (rsp_pressed),
      .rsp_last         (rsp_last)
   );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the pointer event translator core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pet_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 60;
   localparam int MAX_REPORTS   = 10;
   localparam int GAP_MAX       = 6;

   localparam logic [1:0]            MODE_RESERVED = 2'd3;
   localparam logic [INDEX_BITS-1:0] REG_UNUSED    = 2'd3;

   typedef struct packed {
      logic [MASK_BITS-1:0] mask;
      logic [POS_BITS-1:0]  x;
      logic [POS_BITS-1:0]  y;
   } report_type;

   typedef struct packed {
      event_kind_type               kind;
      logic signed [VALUE_BITS-1:0] value_x;
      logic signed [VALUE_BITS-1:0] value_y;
      logic [1:0]                   button_index;
      logic                         pressed;
      logic                         last;
   } pointer_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [MASK_BITS-1:0]         req_button_mask = '0;
   logic [POS_BITS-1:0]          req_pos_x = '0;
   logic [POS_BITS-1:0]          req_pos_y = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_event_kind;
   logic signed [VALUE_BITS-1:0] rsp_value_x;
   logic signed [VALUE_BITS-1:0] rsp_value_y;
   logic [1:0]                   rsp_button_index;
   logic                         rsp_pressed;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [INDEX_BITS-1:0]        csr_index = '0;
   logic [WDATA_BITS-1:0]        csr_wdata = '0;

   report_type         pending_reports[$];
   pointer_result_type expected_events[$];
   pointer_result_type oldest_event;
   report_type         next_report;

   logic [1:0]           mode_shadow   = RESET_MODE;
   logic [SIZE_BITS-1:0] width_shadow  = RESET_WIDTH;
   logic [SIZE_BITS-1:0] height_shadow = RESET_HEIGHT;
   logic [POS_BITS-1:0]  last_x        = '0;
   logic [POS_BITS-1:0]  last_y        = '0;
   logic [MASK_BITS-1:0] last_buttons  = '0;

   int reports_pushed   = 0;
   int reports_accepted = 0;
   int mismatches       = 0;
   int req_gap_max      = 0;
   int rsp_gap_max      = 0;
   int req_gap_left     = 0;
   int rsp_wait         = 0;
   int hold_requests    = 0;
   int holds_done       = 0;
   int hold_left        = 0;
   int idle_cycles      = 0;

   pointer_event_translator_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_mask  (req_button_mask),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_value_x      (rsp_value_x),
      .rsp_value_y      (rsp_value_y),
      .rsp_button_index (rsp_button_index),
      .rsp_pressed      (rsp_pressed),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic signed [VALUE_BITS-1:0] axis_delta(
      input logic [POS_BITS-1:0] coord, input logic [SIZE_BITS-1:0] size,
      input logic [POS_BITS-1:0] previous);
      int c;
      int s;
      int d;
      c = int'(coord);
      s = int'(size);
      if (c <= 0)
         d = 1 - s;
      else if (c >= s - 1)
         d = s - 1;
      else
         d = c - int'(previous);
      return d[VALUE_BITS-1:0];
   endfunction

   function void translate_report(input report_type r);
      pointer_result_type motion;
      pointer_result_type button;
      logic [NUM_BUTTONS-1:0] changed;
      if (mode_shadow == MODE_ABSOLUTE || mode_shadow == MODE_RELATIVE) begin
         motion = '0;
         if (mode_shadow == MODE_RELATIVE) begin
            motion.kind    = EVENT_REL_MOTION;
            motion.value_x = axis_delta(r.x, width_shadow, last_x);
            motion.value_y = axis_delta(r.y, height_shadow, last_y);
            last_x = r.x;
            last_y = r.y;
         end else begin
            motion.kind    = EVENT_ABS_MOTION;
            motion.value_x = {1'b0, r.x};
            motion.value_y = {1'b0, r.y};
         end
         changed = r.mask[NUM_BUTTONS-1:0] ^ last_buttons[NUM_BUTTONS-1:0];
         motion.last = (changed == '0);
         expected_events.push_back(motion);
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (changed[b]) begin
               button              = '0;
               button.kind         = EVENT_BUTTON;
               button.button_index = b[1:0];
               button.pressed      = r.mask[b];
               button.last         = (changed >> (b + 1)) == '0;
               expected_events.push_back(button);
            end
         end
         last_buttons = r.mask;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            translate_report({req_button_mask, req_pos_x, req_pos_y});
            reports_accepted++;
            req_gap_left = $urandom_range(0, req_gap_max);
         end
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reports.size() > 0) begin
            next_report = pending_reports.pop_front();
            req_valid       <= 1'b1;
            req_button_mask <= next_report.mask;
            req_pos_x       <= next_report.x;
            req_pos_y       <= next_report.y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display(
                     "Unexpected event: kind %0d x %0d y %0d button %0d pressed %0b last %0b",
                     rsp_event_kind, rsp_value_x, rsp_value_y, rsp_button_index,
                     rsp_pressed, rsp_last);
            end else begin
               oldest_event = expected_events.pop_front();
               if (rsp_event_kind !== oldest_event.kind ||
                   rsp_value_x !== oldest_event.value_x ||
                   rsp_value_y !== oldest_event.value_y ||
                   rsp_button_index !== oldest_event.button_index ||
                   rsp_pressed !== oldest_event.pressed ||
                   rsp_last !== oldest_event.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display(
                        "Event mismatch: expected kind %0d x %0d y %0d button %0d %0b last %0b",
                        oldest_event.kind, oldest_event.value_x, oldest_event.value_y,
                        oldest_event.button_index, oldest_event.pressed,
                        oldest_event.last);
                     $display(
                        "                got kind %0d x %0d y %0d button %0d %0b last %0b",
                        rsp_event_kind, rsp_value_x, rsp_value_y,
                        rsp_button_index, rsp_pressed, rsp_last);
                  end
               end
            end
            rsp_wait = $urandom_range(0, rsp_gap_max);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_requests != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("pointer_event_translator_core test failed");
         $finish;
      end
   end

   task automatic push_report(input logic [MASK_BITS-1:0] mask, input logic [POS_BITS-1:0] x,
                              input logic [POS_BITS-1:0] y);
      pending_reports.push_back({mask, x, y});
      reports_pushed++;
   endtask

   task automatic wait_drained();
      while (reports_accepted != reports_pushed || expected_events.size() != 0)
         @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_BITS-1:0] index,
                            input logic [WDATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         REG_POINTER_MODE:  mode_shadow   = data[1:0];
         REG_SCREEN_WIDTH:  width_shadow  = data[SIZE_BITS-1:0];
         REG_SCREEN_HEIGHT: height_shadow = data[SIZE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_pacing();
      req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 13'd1;
         1: return 13'd4096;
         2: return 13'd0;
         3: return 13'd8191;
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   function automatic logic [POS_BITS-1:0] pick_coord(input logic [SIZE_BITS-1:0] size);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 16'(size - 1);
         2: return 16'(size - 2);
         3: return 16'hFFFF;
         4, 5: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, int'(size)));
      endcase
   endfunction

   task automatic random_config();
      logic [1:0] mode;
      case ($urandom_range(0, 9))
         0: mode = MODE_NONE;
         1: mode = MODE_RESERVED;
         2, 3, 4, 5: mode = MODE_ABSOLUTE;
         default: mode = MODE_RELATIVE;
      endcase
      write_reg(REG_POINTER_MODE, 13'(mode));
      write_reg(REG_SCREEN_WIDTH, pick_size());
      write_reg(REG_SCREEN_HEIGHT, pick_size());
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++)
         push_report(8'($urandom_range(0, 255)), pick_coord(width_shadow),
                     pick_coord(height_shadow));
   endtask

   initial begin
      @(negedge reset);
      @(posedge clock);

      set_pacing();
      push_report(8'h00, 16'h0000, 16'h0000);
      push_report(8'hFF, 16'hFFFF, 16'hFFFF);
      push_report(8'h00, 16'h1234, 16'h00FF);
      push_report(8'hF8, 16'h0000, 16'h0000);
      push_report(8'h02, 16'h0005, 16'h0006);
      push_report(8'h05, 16'h0007, 16'h0008);

      wait_idle();
      write_reg(REG_POINTER_MODE, 13'(MODE_RELATIVE));
      set_pacing();
      push_report(8'h00, 16'd0, 16'd0);
      push_report(8'h01, 16'd1919, 16'd1079);
      push_report(8'h00, 16'd1918, 16'd1078);
      push_report(8'h00, 16'd1, 16'd1);
      push_report(8'h07, 16'hFFFF, 16'hFFFF);
      push_report(8'h03, 16'd100, 16'd200);

      wait_idle();
      write_reg(REG_UNUSED, 13'h1ABC);
      write_reg(REG_POINTER_MODE, 13'(MODE_NONE));
      push_report(8'h07, 16'd10, 16'd20);
      wait_idle();
      write_reg(REG_POINTER_MODE, 13'(MODE_RESERVED));
      push_report(8'h00, 16'd30, 16'd40);
      wait_idle();
      write_reg(REG_POINTER_MODE, 13'(MODE_RELATIVE));
      push_report(8'h06, 16'd50, 16'd60);

      wait_idle();
      write_reg(REG_SCREEN_WIDTH, 13'd1);
      write_reg(REG_SCREEN_HEIGHT, 13'd4096);
      push_report(8'h00, 16'd0, 16'd0);
      push_report(8'h00, 16'd1, 16'd4095);
      push_report(8'h01, 16'd2, 16'd4094);

      wait_idle();
      write_reg(REG_SCREEN_WIDTH, 13'd0);
      write_reg(REG_SCREEN_HEIGHT, 13'd8191);
      push_report(8'h00, 16'd0, 16'd5);
      push_report(8'h00, 16'd9, 16'd8190);
      push_report(8'h00, 16'd0, 16'd8189);

      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         random_config();
         set_pacing();
         push_random(6);
         if (phase % 2 == 1)
            wait_drained();
         push_random(6);
      end

      wait_idle();
      write_reg(REG_POINTER_MODE, 13'(MODE_RELATIVE));
      write_reg(REG_SCREEN_WIDTH, 13'd640);
      write_reg(REG_SCREEN_HEIGHT, 13'd480);
      req_gap_max = 0;
      rsp_gap_max = 0;
      push_random(30);
      @(posedge clock);
      hold_requests++;

      wait_idle();
      write_reg(REG_POINTER_MODE, 13'(MODE_ABSOLUTE));
      set_pacing();
      push_random(10);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("pointer_event_translator_core test passed");
      end else begin
         $display("pointer_event_translator_core test failed");
      end
      $finish;
   end

endmodule
